// ===== rtl/core/cpbb_pkg.sv =====
// Shared types and constants for the cascaded PI buck/boost controller.
// No dependencies; imported by cascaded_pi_buck_boost_control.
package cpbb_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_VI,
        S_VP,
        S_IREF,
        S_CI,
        S_CP,
        S_DUTY,
        S_CMP,
        S_FIN
    } t_state;

    // reported drive state
    typedef enum logic [1:0] {
        DRIVE_IDLE  = 2'd0,
        DRIVE_BUCK  = 2'd1,
        DRIVE_BOOST = 2'd2,
        DRIVE_FAULT = 2'd3
    } t_drive;

    // operating_mode codes
    localparam logic [1:0] MODE_BUCK  = 2'd1;
    localparam logic [1:0] MODE_BOOST = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_TARGET  = 3'd1;
    localparam logic [2:0] REG_CLIMIT  = 3'd2;
    localparam logic [2:0] REG_VKP     = 3'd3;
    localparam logic [2:0] REG_VKI     = 3'd4;
    localparam logic [2:0] REG_CKP     = 3'd5;
    localparam logic [2:0] REG_CKI     = 3'd6;
    localparam logic [2:0] REG_PERIOD  = 3'd7;

    // register reset values
    localparam logic [23:0] VKP_RST    = 24'd335544;
    localparam logic [23:0] VKI_RST    = 24'd34;
    localparam logic [23:0] CKP_RST    = 24'd167772;
    localparam logic [23:0] CKI_RST    = 24'd17;
    localparam logic [15:0] PERIOD_RST = 16'd960;

    // fixed-point limits
    localparam logic signed [41:0] Q30_ONE      = 42'sd1073741824;
    localparam logic signed [41:0] Q30_DUTY_MAX = 42'sd1052266988;
    localparam logic [15:0]        Q16_BUCK_MAX  = 16'd62259;
    localparam logic [15:0]        Q16_BOOST_MIN = 16'd3277;
    localparam logic [16:0]        Q16_ONE       = 17'd65536;

    // comparator debounce and brake hold
    localparam logic [1:0] DEBOUNCE_TICKS = 2'd3;
    localparam logic [3:0] HOLD_TICKS     = 4'd10;

endpackage

// ===== rtl/core/cascaded_pi_buck_boost_control.sv =====
// Cascaded PI voltage/current controller for a buck/boost stage, single module.
// Depends on cpbb_pkg (types, register indexes, fixed-point constants).
//
// One request is one control tick: voltage and current samples, a fault flag and
// the boost comparator bit. An outer PI voltage loop (Q8.32 integrator, clamped to
// the current limit) feeds an inner PI current loop (Q2.30 integrator) whose output
// is clamped to a 0..0.98 duty. Buck emits min(duty,0.95)*period, boost emits
// (1-max(duty,0.05))*period with a debounced comparator trip that holds the brake
// for HOLD_TICKS ticks. A fault latches, clears both integrators and emits zeros.
// All five multiplies of a tick run on one signed 25x27 multiplier whose product
// is registered, stepped by a nine-state sequencer: a normal tick runs from idle
// through VI, VP, IREF, CI, CP, DUTY, CMP and FIN, a fault tick through CMP and
// FIN only; the result sits in an output register, so a stalled result holds the
// sequencer only in its final state. o_stall is high whenever it is not idle.
// Configuration is a plain write port (index, data); writing operating_mode clears
// both integrators and the fault latch. Write registers only while idle.
module cascaded_pi_buck_boost_control
    import cpbb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // tick request
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_voltage_sample,
    input  logic signed [15:0] i_current_sample,
    input  logic               i_fault_present,
    input  logic               i_comparator_trip,
    // result
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_compare_value,
    output logic               o_brake_on,
    output logic [1:0]         o_drive_state,
    output logic [15:0]        o_duty_applied,
    output logic signed [15:0] o_voltage_integral_out
);

    // sequencer
    t_state r_state, n_state;

    // configuration registers
    logic [1:0]  r_mode;
    logic [15:0] r_target;
    logic [14:0] r_climit;
    logic [23:0] r_vkp, r_vki, r_ckp, r_cki;
    logic [15:0] r_period;

    // loop state
    logic signed [39:0] r_vint, n_vint;   // Q8.32
    logic signed [31:0] r_cint, n_cint;   // Q2.30
    logic [1:0]         r_dc, n_dc;
    logic [3:0]         r_hold, n_hold;
    logic               r_fault, n_fault;

    // per-tick working registers
    logic signed [16:0] r_err_v, n_err_v;  // Q8.8
    logic signed [15:0] r_is, n_is;
    logic               r_trip, n_trip;
    logic signed [26:0] r_err_i, n_err_i;  // Q8.16
    logic signed [51:0] r_prod;
    logic [16:0]        r_cmp_op, n_cmp_op;
    logic               r_res_brake, n_res_brake;
    t_drive             r_res_drive, n_res_drive;
    logic [15:0]        r_res_applied, n_res_applied;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_o_cmp;
    logic               r_o_brake;
    t_drive             r_o_drive;
    logic [15:0]        r_o_applied;
    logic signed [15:0] r_o_vint;

    // shared multiplier
    logic signed [24:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [51:0] mul_p;

    // datapath intermediates
    logic signed [41:0] lim42, vint42, vsum, vclamp, iref, iref_c;
    logic signed [41:0] cint42, csum, u;
    logic [15:0]        duty16, applied_b;
    t_drive             drive;
    logic [1:0]         dc_t;
    logic [3:0]         hold_t;
    logic               accept, ld_out;

    assign mul_p = mul_a * mul_b;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_fault_present ? S_CMP : S_VI;
                end
            end
            S_VI:   n_state = S_VP;
            S_VP:   n_state = S_IREF;
            S_IREF: n_state = S_CI;
            S_CI:   n_state = S_CP;
            S_CP:   n_state = S_DUTY;
            S_DUTY: n_state = S_CMP;
            S_CMP:  n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        o_stall = (r_state != S_IDLE);
        accept  = (r_state == S_IDLE) && i_valid;
        ld_out  = (r_state == S_FIN) && (!r_out_valid || !i_stall);
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            S_VI: begin
                mul_a = $signed({1'b0, r_vki});
                mul_b = $signed({{10{r_err_v[16]}}, r_err_v});
            end
            S_VP: begin
                mul_a = $signed({1'b0, r_vkp});
                mul_b = $signed({{10{r_err_v[16]}}, r_err_v});
            end
            S_CI: begin
                mul_a = $signed({1'b0, r_cki});
                mul_b = r_err_i;
            end
            S_CP: begin
                mul_a = $signed({1'b0, r_ckp});
                mul_b = r_err_i;
            end
            S_CMP: begin
                mul_a = $signed({8'b0, r_cmp_op});
                mul_b = $signed({11'b0, r_period});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        lim42  = $signed({3'b0, r_climit, 24'b0});
        vint42 = $signed({{2{r_vint[39]}}, r_vint});
        cint42 = $signed({{10{r_cint[31]}}, r_cint});

        // voltage integrator update
        vsum = vint42 + $signed(r_prod[41:0]);
        if (vsum > lim42)       vclamp = lim42;
        else if (vsum < -lim42) vclamp = -lim42;
        else                    vclamp = vsum;

        // current reference, clamp only when a limit is set
        iref   = $signed(r_prod[41:0]) + vint42;
        iref_c = iref;
        if (r_climit != '0) begin
            if (iref > lim42)       iref_c = lim42;
            else if (iref < -lim42) iref_c = -lim42;
        end

        // current integrator update (floor shift by 10)
        csum = cint42 + $signed(r_prod[51:10]);

        // loop output and duty
        u = $signed(r_prod[51:10]) + cint42;
        if (u < 0)                 duty16 = '0;
        else if (u > Q30_DUTY_MAX) duty16 = Q30_DUTY_MAX[29:14];
        else                       duty16 = u[29:14];

        if (r_fault)                  drive = DRIVE_FAULT;
        else if (r_mode == MODE_BUCK)  drive = DRIVE_BUCK;
        else if (r_mode == MODE_BOOST) drive = DRIVE_BOOST;
        else                          drive = DRIVE_IDLE;

        // comparator debounce and brake hold
        if (r_trip) begin
            dc_t = (r_dc < DEBOUNCE_TICKS) ? r_dc + 2'd1 : r_dc;
        end else begin
            dc_t = '0;
        end
        hold_t    = (r_trip && dc_t >= DEBOUNCE_TICKS) ? HOLD_TICKS : r_hold;
        applied_b = (duty16 > Q16_BOOST_MIN) ? duty16 : Q16_BOOST_MIN;

        // defaults: hold
        n_vint        = r_vint;
        n_cint        = r_cint;
        n_dc          = r_dc;
        n_hold        = r_hold;
        n_fault       = r_fault;
        n_err_v       = r_err_v;
        n_is          = r_is;
        n_trip        = r_trip;
        n_err_i       = r_err_i;
        n_cmp_op      = r_cmp_op;
        n_res_brake   = r_res_brake;
        n_res_drive   = r_res_drive;
        n_res_applied = r_res_applied;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_err_v = $signed({1'b0, r_target}) - $signed({1'b0, i_voltage_sample});
                    n_is    = i_current_sample;
                    n_trip  = i_comparator_trip;
                    if (i_fault_present) begin
                        n_fault       = 1'b1;
                        n_vint        = '0;
                        n_cint        = '0;
                        n_cmp_op      = '0;
                        n_res_brake   = 1'b0;
                        n_res_drive   = DRIVE_FAULT;
                        n_res_applied = '0;
                    end
                end
            end
            S_VP:   n_vint = vclamp[39:0];
            S_IREF: n_err_i = $signed({iref_c[41], iref_c[41:16]})
                            - $signed({{3{r_is[15]}}, r_is, 8'b0});
            S_CP: begin
                if (csum > Q30_ONE)       n_cint = Q30_ONE[31:0];
                else if (csum < -Q30_ONE) n_cint = 32'(-Q30_ONE);
                else                      n_cint = csum[31:0];
            end
            S_DUTY: begin
                n_res_drive   = drive;
                n_res_brake   = 1'b0;
                n_res_applied = '0;
                n_cmp_op      = '0;
                case (drive)
                    DRIVE_BUCK: begin
                        n_res_applied = (duty16 < Q16_BUCK_MAX) ? duty16 : Q16_BUCK_MAX;
                        n_cmp_op      = {1'b0, n_res_applied};
                    end
                    DRIVE_BOOST: begin
                        n_dc = dc_t;
                        if (hold_t != '0) begin
                            n_res_brake   = 1'b1;
                            n_res_applied = Q16_BOOST_MIN;
                            n_hold        = hold_t - 4'd1;
                        end else begin
                            n_res_applied = applied_b;
                            n_hold        = hold_t;
                        end
                        n_cmp_op = Q16_ONE - {1'b0, n_res_applied};
                    end
                    default: begin
                        n_cmp_op = '0;
                    end
                endcase
            end
            default: begin
                n_vint = r_vint;
            end
        endcase

        // mode write: clear both integrators and the fault latch
        if (i_cfg_we && i_cfg_index == REG_MODE) begin
            n_vint  = '0;
            n_cint  = '0;
            n_fault = 1'b0;
        end

        n_out_valid = ld_out || (r_out_valid && i_stall);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= '0;
            r_target    <= '0;
            r_climit    <= '0;
            r_vkp       <= VKP_RST;
            r_vki       <= VKI_RST;
            r_ckp       <= CKP_RST;
            r_cki       <= CKI_RST;
            r_period    <= PERIOD_RST;
            r_vint      <= '0;
            r_cint      <= '0;
            r_dc        <= '0;
            r_hold      <= '0;
            r_fault     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_vint      <= n_vint;
            r_cint      <= n_cint;
            r_dc        <= n_dc;
            r_hold      <= n_hold;
            r_fault     <= n_fault;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[1:0];
                    REG_TARGET: r_target <= i_cfg_data[15:0];
                    REG_CLIMIT: r_climit <= i_cfg_data[14:0];
                    REG_VKP:    r_vkp    <= i_cfg_data;
                    REG_VKI:    r_vki    <= i_cfg_data;
                    REG_CKP:    r_ckp    <= i_cfg_data;
                    REG_CKI:    r_cki    <= i_cfg_data;
                    REG_PERIOD: r_period <= i_cfg_data[15:0];
                    default:    r_period <= r_period;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_err_v       <= n_err_v;
        r_is          <= n_is;
        r_trip        <= n_trip;
        r_err_i       <= n_err_i;
        // compare product must survive a stalled final state
        if (r_state != S_FIN) begin
            r_prod <= mul_p;
        end
        r_cmp_op      <= n_cmp_op;
        r_res_brake   <= n_res_brake;
        r_res_drive   <= n_res_drive;
        r_res_applied <= n_res_applied;
        if (ld_out) begin
            r_o_cmp     <= r_prod[31:16];
            r_o_brake   <= r_res_brake;
            r_o_drive   <= r_res_drive;
            r_o_applied <= r_res_applied;
            r_o_vint    <= r_vint[39:24];
        end
    end

    assign o_valid                = r_out_valid;
    assign o_compare_value        = r_o_cmp;
    assign o_brake_on             = r_o_brake;
    assign o_drive_state          = r_o_drive;
    assign o_duty_applied         = r_o_applied;
    assign o_voltage_integral_out = r_o_vint;

    // ---------------- assertions ----------------
    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_VI || r_state == S_CMP))
        else $error("tick accepted but sequencer did not start");

    a_cint_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($signed({{10{r_cint[31]}}, r_cint}) <= Q30_ONE &&
         $signed({{10{r_cint[31]}}, r_cint}) >= -Q30_ONE))
        else $error("current integrator outside +-1.0");

    a_brake_boost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brake_on) |-> (o_drive_state == DRIVE_BOOST))
        else $error("brake asserted outside boost");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold <= HOLD_TICKS)
        else $error("brake hold count out of range");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside final state");

endmodule
